// ----- rtl/erx_pkg.sv -----
// erx_pkg: shared types and constants for the exponential relaxation step core
// no dependencies; imported by the cell modules and the core, not by the interfaces
`default_nettype none

package erx_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned N_TERMS  = 20;
    localparam int unsigned N_SQUARE = 6;
    localparam int unsigned QUO_W    = 34;

    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [47:0] EXP_CAP  = 48'd50 << FRAC_W;
    localparam logic [47:0] HALF_Q   = 48'd1 << (FRAC_W - 1);
    localparam logic [63:0] RND_Q31  = 64'd1 << 30;

    // register index codes (paddr[2])
    localparam logic RATE_FLOOR_IDX = 1'b0;

    // per-request context handed from stage to stage
    typedef struct packed {
        logic [31:0] phi_raw;
        logic        pn;
        logic        an;
        logic [31:0] phi_m;
        logic [31:0] ab_m;
        logic [31:0] beta;
        logic        byp;
        logic [47:0] x;
        logic        k;
        logic [30:0] y;
        logic [31:0] term;
        logic [32:0] s;
        logic [32:0] q0;
        logic [62:0] prod;
        logic [31:0] e;
        logic [31:0] ome;
        logic [31:0] g;
        logic [47:0] g_rem;
        logic [33:0] g_quo;
        logic        g_ovf;
        logic [62:0] qe_rem;
        logic [33:0] qe_quo;
        logic        qe_ovf;
        logic [62:0] qa_rem;
        logic [33:0] qa_quo;
        logic        qa_ovf;
        logic [31:0] pe;
        logic [31:0] pg;
    } ctx_t;

endpackage

`default_nettype wire

// ----- rtl/erx_in_if.sv -----
// erx_in_if: request channel carrying one input component
// depends on nothing
`default_nettype none

interface erx_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] phi;
    logic        [31:0] time_step;
    logic signed [31:0] source_term;
    logic        [31:0] decay_rate;

    modport source (output valid, phi, time_step, source_term, decay_rate, input ready);
    modport sink   (input valid, phi, time_step, source_term, decay_rate, output ready);
endinterface

`default_nettype wire

// ----- rtl/erx_out_if.sv -----
// erx_out_if: result channel carrying end value, step average and clamp flag
// depends on nothing
`default_nettype none

interface erx_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] end_value;
    logic signed [31:0] step_average;
    logic               saturated;

    modport source (output valid, end_value, step_average, saturated, input ready);
    modport sink   (input valid, end_value, step_average, saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/erx_term_cell.sv -----
// erx_term_cell: one taylor series term of exp(-y), three register stages
// depends on erx_pkg
`default_nettype none

module erx_term_cell
    import erx_pkg::*;
#(
    parameter int unsigned N = 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic valid_in,
    input  ctx_t ctx_in,
    output logic valid_out,
    output ctx_t ctx_out
);

    localparam int unsigned RECIP_SH = 36;
    localparam logic [36:0] RECIP    = 37'((64'd1 << RECIP_SH) / N);

    logic va_reg, vb_reg, vc_reg;
    ctx_t ca_reg, cb_reg, cc_reg;
    ctx_t ca_next, cb_next, cc_next;
    logic [68:0] qm;
    logic [37:0] qn;
    logic [32:0] rem;
    logic [32:0] q;

    always_comb
    begin
        ca_next      = ctx_in;
        ca_next.prod = 63'(ctx_in.term) * 63'(ctx_in.y);
    end

    // truncated divide by n: reciprocal multiply, then one correction
    always_comb
    begin
        cb_next      = ca_reg;
        cb_next.term = ca_reg.prod[62:31];
        qm           = 69'(ca_reg.prod[62:31]) * 69'(RECIP);
        cb_next.q0   = qm[68:36];
    end

    always_comb
    begin
        cc_next = cb_reg;
        qn      = 38'(cb_reg.q0) * 38'(N);
        rem     = 33'(cb_reg.term) - qn[32:0];
        q       = (rem >= 33'(N)) ? cb_reg.q0 + 33'd1 : cb_reg.q0;
        cc_next.term = q[31:0];
        if ((N % 2) == 1)
        begin
            cc_next.s = (q > cb_reg.s) ? 33'd0 : cb_reg.s - q;
        end
        else
        begin
            cc_next.s = cb_reg.s + q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ca_reg <= ca_next;
            cb_reg <= cb_next;
            cc_reg <= cc_next;
        end
    end

    assign valid_out = vc_reg;
    assign ctx_out   = cc_reg;

endmodule

`default_nettype wire

// ----- rtl/erx_sq_cell.sv -----
// erx_sq_cell: one rounded squaring step that undoes the argument scaling
// depends on erx_pkg
`default_nettype none

module erx_sq_cell
    import erx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic valid_in,
    input  ctx_t ctx_in,
    output logic valid_out,
    output ctx_t ctx_out
);

    logic        v_reg;
    ctx_t        c_reg;
    ctx_t        c_next;
    logic [63:0] sq;

    always_comb
    begin
        c_next = ctx_in;
        sq     = 64'(ctx_in.e) * 64'(ctx_in.e) + RND_Q31;
        if (ctx_in.k)
        begin
            c_next.e = sq[62:31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg <= c_next;
        end
    end

    assign valid_out = v_reg;
    assign ctx_out   = c_reg;

endmodule

`default_nettype wire

// ----- rtl/erx_div_cell.sv -----
// erx_div_cell: one restoring quotient bit for the dividers of the block
// depends on erx_pkg; phase 0 runs the g and end lanes, phase 1 the average lane
`default_nettype none

module erx_div_cell
    import erx_pkg::*;
#(
    parameter int unsigned PHASE = 0,
    parameter int unsigned BIT   = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic valid_in,
    input  ctx_t ctx_in,
    output logic valid_out,
    output ctx_t ctx_out
);

    logic        v_reg;
    ctx_t        c_reg;
    ctx_t        c_next;
    logic [62:0] den;

    always_comb
    begin
        c_next = ctx_in;
        den    = 63'({ctx_in.beta, 15'b0});
        if (PHASE == 0)
        begin
            if (!ctx_in.g_ovf && ((ctx_in.g_rem >> BIT) >= ctx_in.x))
            begin
                c_next.g_rem      = ctx_in.g_rem - 48'(ctx_in.x << BIT);
                c_next.g_quo[BIT] = 1'b1;
            end
            if (!ctx_in.qe_ovf && ((ctx_in.qe_rem >> BIT) >= den))
            begin
                c_next.qe_rem      = ctx_in.qe_rem - (den << BIT);
                c_next.qe_quo[BIT] = 1'b1;
            end
        end
        else
        begin
            if (!ctx_in.qa_ovf && ((ctx_in.qa_rem >> BIT) >= den))
            begin
                c_next.qa_rem      = ctx_in.qa_rem - (den << BIT);
                c_next.qa_quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg <= c_next;
        end
    end

    assign valid_out = v_reg;
    assign ctx_out   = c_reg;

endmodule

`default_nettype wire

// ----- rtl/exponential_relaxation_step_core.sv -----
// exponential_relaxation_step_core: takes one request per cycle while the result
// is not stalled; the whole core is one stall-as-a-unit pipeline whose depth is
// set by 20 series cells of three stages and two 34-stage dividers; a result
// waiting on a stalled output holds every stage; bubbles do not collapse
// rst_n asynchronously clears all valid bits and rate_floor; payload is not reset
`default_nettype none

module exponential_relaxation_step_core
    import erx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    erx_in_if.sink      item,
    erx_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration port, one register
    // ---------------------------------------------------------------
    logic [31:0] rate_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_floor_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == RATE_FLOOR_IDX))
        begin
            rate_floor_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == RATE_FLOOR_IDX) ? rate_floor_reg : 32'd0;
    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // global advance: every stage moves unless the result is stalled
    // ---------------------------------------------------------------
    logic advance;
    logic out_v_reg;

    assign advance    = !out_v_reg || result.ready;
    assign item.ready = advance;

    // ---------------------------------------------------------------
    // stage 0: capture request, magnitudes, x = beta*dt >> frac
    // ---------------------------------------------------------------
    logic        s0_v_reg;
    ctx_t        s0_reg, s0_next;
    logic [63:0] bdt;

    always_comb
    begin
        s0_next         = '0;
        s0_next.phi_raw = item.phi;
        s0_next.pn      = item.phi[31];
        s0_next.phi_m   = item.phi[31] ? (~item.phi) + 32'd1 : item.phi;
        s0_next.an      = item.source_term[31];
        s0_next.ab_m    = item.source_term[31] ? (~item.source_term) + 32'd1
                                                : item.source_term;
        s0_next.beta    = item.decay_rate;
        bdt             = 64'(item.decay_rate) * 64'(item.time_step);
        s0_next.x       = bdt[63:16];
        s0_next.byp     = (item.decay_rate <= rate_floor_reg);
    end

    // ---------------------------------------------------------------
    // stage 1: cap exponent, pick direct or scaled-by-64 argument
    // ---------------------------------------------------------------
    logic        s1_v_reg;
    ctx_t        s1_reg, s1_next;
    logic [47:0] xc;

    always_comb
    begin
        s1_next      = s0_reg;
        s1_next.byp  = s0_reg.byp || (s0_reg.x == 48'd0);
        xc           = (s0_reg.x > EXP_CAP) ? EXP_CAP : s0_reg.x;
        s1_next.k    = (xc >= HALF_Q);
        s1_next.y    = s1_next.k ? 31'(xc << 9) : 31'(xc << 15);
        s1_next.term = ONE_Q31;
        s1_next.s    = 33'(ONE_Q31);
    end

    // ---------------------------------------------------------------
    // series: 20 term cells, each handing term and partial sum along
    // ---------------------------------------------------------------
    logic term_v   [0:N_TERMS];
    ctx_t term_ctx [0:N_TERMS];

    assign term_v[0]   = s1_v_reg;
    assign term_ctx[0] = s1_reg;

    for (genvar i = 0; i < N_TERMS; i++)
    begin : g_term
        erx_term_cell #(
            .N (i + 1)
        ) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (term_v[i]),
            .ctx_in    (term_ctx[i]),
            .valid_out (term_v[i + 1]),
            .ctx_out   (term_ctx[i + 1])
        );
    end

    // ---------------------------------------------------------------
    // stage 2: cap series sum at one
    // ---------------------------------------------------------------
    logic s2_v_reg;
    ctx_t s2_reg, s2_next;

    always_comb
    begin
        s2_next   = term_ctx[N_TERMS];
        s2_next.e = (term_ctx[N_TERMS].s > 33'(ONE_Q31)) ? ONE_Q31
                                                          : term_ctx[N_TERMS].s[31:0];
    end

    // ---------------------------------------------------------------
    // squaring chain, active only for the scaled argument
    // ---------------------------------------------------------------
    logic sq_v   [0:N_SQUARE];
    ctx_t sq_ctx [0:N_SQUARE];

    assign sq_v[0]   = s2_v_reg;
    assign sq_ctx[0] = s2_reg;

    for (genvar i = 0; i < N_SQUARE; i++)
    begin : g_sq
        erx_sq_cell u_sq (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (sq_v[i]),
            .ctx_in    (sq_ctx[i]),
            .valid_out (sq_v[i + 1]),
            .ctx_out   (sq_ctx[i + 1])
        );
    end

    // ---------------------------------------------------------------
    // stage 3: 1 - e, dividends for g and for the end source term
    // 1 - e reaches a full one when e underflows, so the g dividend
    // keeps all 48 bits
    // ---------------------------------------------------------------
    logic        s3_v_reg;
    ctx_t        s3_reg, s3_next;
    logic [63:0] pe_src;

    always_comb
    begin
        s3_next        = sq_ctx[N_SQUARE];
        s3_next.ome    = ONE_Q31 - sq_ctx[N_SQUARE].e;
        s3_next.g_rem  = {s3_next.ome, 16'b0};
        pe_src         = 64'(sq_ctx[N_SQUARE].ab_m) * 64'(s3_next.ome);
        s3_next.qe_rem = pe_src[62:0];
    end

    // ---------------------------------------------------------------
    // stage 4: quotient overflow checks (quotient of 2^34 or more)
    // ---------------------------------------------------------------
    logic s4_v_reg;
    ctx_t s4_reg, s4_next;

    always_comb
    begin
        s4_next        = s3_reg;
        s4_next.g_ovf  = (48'(s3_reg.g_rem >> 34) >= s3_reg.x);
        s4_next.qe_ovf = (47'(s3_reg.qe_rem >> 34) >= {s3_reg.beta, 15'b0});
        s4_next.g_quo  = '0;
        s4_next.qe_quo = '0;
    end

    // ---------------------------------------------------------------
    // divider row A: g = (1-e)/x and end source quotient side by side
    // ---------------------------------------------------------------
    logic da_v   [0:QUO_W];
    ctx_t da_ctx [0:QUO_W];

    assign da_v[0]   = s4_v_reg;
    assign da_ctx[0] = s4_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div_a
        erx_div_cell #(
            .PHASE (0),
            .BIT   (QUO_W - 1 - i)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (da_v[i]),
            .ctx_in    (da_ctx[i]),
            .valid_out (da_v[i + 1]),
            .ctx_out   (da_ctx[i + 1])
        );
    end

    // ---------------------------------------------------------------
    // stage 5: cap g at one
    // ---------------------------------------------------------------
    logic s5_v_reg;
    ctx_t s5_reg, s5_next;

    always_comb
    begin
        s5_next   = da_ctx[QUO_W];
        s5_next.g = (da_ctx[QUO_W].g_ovf || (da_ctx[QUO_W].g_quo > 34'(ONE_Q31)))
                    ? ONE_Q31 : da_ctx[QUO_W].g_quo[31:0];
    end

    // ---------------------------------------------------------------
    // stage 6: average source dividend and phi*e
    // ---------------------------------------------------------------
    logic        s6_v_reg;
    ctx_t        s6_reg, s6_next;
    logic [63:0] pa_src;
    logic [63:0] pe_phi;

    always_comb
    begin
        s6_next        = s5_reg;
        pa_src         = 64'(s5_reg.ab_m) * 64'(ONE_Q31 - s5_reg.g);
        s6_next.qa_rem = pa_src[62:0];
        pe_phi         = 64'(s5_reg.phi_m) * 64'(s5_reg.e) + RND_Q31;
        s6_next.pe     = pe_phi[62:31];
    end

    // ---------------------------------------------------------------
    // stage 7: overflow check for the average divider
    // ---------------------------------------------------------------
    logic s7_v_reg;
    ctx_t s7_reg, s7_next;

    always_comb
    begin
        s7_next        = s6_reg;
        s7_next.qa_ovf = (47'(s6_reg.qa_rem >> 34) >= {s6_reg.beta, 15'b0});
        s7_next.qa_quo = '0;
    end

    // ---------------------------------------------------------------
    // divider row B: average source quotient
    // ---------------------------------------------------------------
    logic db_v   [0:QUO_W];
    ctx_t db_ctx [0:QUO_W];

    assign db_v[0]   = s7_v_reg;
    assign db_ctx[0] = s7_reg;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div_b
        erx_div_cell #(
            .PHASE (1),
            .BIT   (QUO_W - 1 - i)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (db_v[i]),
            .ctx_in    (db_ctx[i]),
            .valid_out (db_v[i + 1]),
            .ctx_out   (db_ctx[i + 1])
        );
    end

    // ---------------------------------------------------------------
    // stage 8: phi*g; overflowed quotients pin to all ones, which is
    // already far past the output range and clamps the same way
    // ---------------------------------------------------------------
    logic        s8_v_reg;
    ctx_t        s8_reg, s8_next;
    logic [63:0] pg_phi;

    always_comb
    begin
        s8_next    = db_ctx[QUO_W];
        pg_phi     = 64'(db_ctx[QUO_W].phi_m) * 64'(db_ctx[QUO_W].g) + RND_Q31;
        s8_next.pg = pg_phi[62:31];
        if (db_ctx[QUO_W].qe_ovf)
        begin
            s8_next.qe_quo = '1;
        end
        if (db_ctx[QUO_W].qa_ovf)
        begin
            s8_next.qa_quo = '1;
        end
    end

    // ---------------------------------------------------------------
    // output register: signed sums, clamp, fall-back path
    // ---------------------------------------------------------------
    function automatic logic [32:0] sum_clamp(
        input logic        pn,
        input logic [31:0] pm,
        input logic        an,
        input logic [33:0] qm
    );
        logic signed [36:0] a;
        logic signed [36:0] b;
        logic signed [36:0] s;
        a = pn ? -$signed(37'(pm)) : $signed(37'(pm));
        b = an ? -$signed(37'(qm)) : $signed(37'(qm));
        s = a + b;
        if (s > 37'sd2147483647)
        begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        else if (s < -37'sd2147483648)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, s[31:0]};
    endfunction

    logic [31:0] end_reg, avg_reg;
    logic        sat_reg;
    logic [31:0] end_next, avg_next;
    logic        sat_next;
    logic [32:0] end_sc, avg_sc;

    always_comb
    begin
        end_sc = sum_clamp(s8_reg.pn, s8_reg.pe, s8_reg.an, s8_reg.qe_quo);
        avg_sc = sum_clamp(s8_reg.pn, s8_reg.pg, s8_reg.an, s8_reg.qa_quo);
        if (s8_reg.byp)
        begin
            end_next = s8_reg.phi_raw;
            avg_next = s8_reg.phi_raw;
            sat_next = 1'b0;
        end
        else
        begin
            end_next = end_sc[31:0];
            avg_next = avg_sc[31:0];
            sat_next = end_sc[32] || avg_sc[32];
        end
    end

    // ---------------------------------------------------------------
    // top-level stage registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_v_reg  <= item.valid;
            s1_v_reg  <= s0_v_reg;
            s2_v_reg  <= term_v[N_TERMS];
            s3_v_reg  <= sq_v[N_SQUARE];
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= da_v[QUO_W];
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= db_v[QUO_W];
            out_v_reg <= s8_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg  <= s0_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            end_reg <= end_next;
            avg_reg <= avg_next;
            sat_reg <= sat_next;
        end
    end

    assign result.valid        = out_v_reg;
    assign result.end_value    = end_reg;
    assign result.step_average = avg_reg;
    assign result.saturated    = sat_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
`ifndef SYNTHESIS
    // a stalled result freezes the whole pipe, so no request is taken
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !item.ready)
        else $error("request taken while result stalled");

    // the flag only comes from an output clamp
    a_sat_means_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |->
            (result.end_value == 32'sh7FFF_FFFF || result.end_value == 32'sh8000_0000 ||
             result.step_average == 32'sh7FFF_FFFF ||
             result.step_average == 32'sh8000_0000))
        else $error("saturated set without a clamped result");

    // a new result only appears on a cycle where the pipe moved
    a_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(advance))
        else $error("result appeared without pipeline advance");
`endif

endmodule

`default_nettype wire
